@@ hw/rtl/swmm_pkg.sv @@
// Package for the sliding window min/max tracker.
// Sizes, register indexes and the controller/datapath interface types.
// No dependencies.
package swmm_pkg;

    localparam int DEPTH     = 128;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 8;
    localparam int FILL_W    = 8;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_TRACKING     = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 8'd128;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic accept;      // latch input word, read evicted entry
        logic eval;        // write new sample, decide on rescan
        logic scan_issue;  // issue one rescan read
        logic update;      // commit min/max, position, count
        logic out_load;    // load result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/swmm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/swmm_ctrl.sv @@
// Controller state machine for the sliding window min/max tracker.
// Depends on swmm_pkg.
module swmm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  swmm_pkg::dp_status_t  status,
    output swmm_pkg::ctrl_cmd_t   cmd
);
    import swmm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.eval   = 1'b1;
                state_next = status.scan_needed ? ST_SCAN : ST_UPD;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/swmm_dp.sv @@
// Datapath for the sliding window min/max tracker: config registers,
// window store, rescan reduction, tracked extremes and result register.
// Depends on swmm_pkg and swmm_ram.
module swmm_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [swmm_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [swmm_pkg::CFG_W-1:0]         cfg_wdata,
    input  swmm_pkg::sample_t                  s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output swmm_pkg::sample_t                  m_window_min,
    output swmm_pkg::sample_t                  m_window_max,
    output logic [swmm_pkg::FILL_W-1:0]        m_fill_count,
    input  swmm_pkg::ctrl_cmd_t                cmd,
    output swmm_pkg::dp_status_t               status
);
    import swmm_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic              track_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [CNT_W-1:0]  count_reg;
    sample_t           sample_reg;
    sample_t           min_reg, max_reg;
    sample_t           min_next, max_next;
    logic [ADDR_W-1:0] scan_idx_reg;
    logic              rd_vld_reg, rd_first_reg;
    logic              scan_max_reg, did_scan_reg;
    sample_t           best_reg;
    logic              m_valid_reg;
    sample_t           m_min_reg, m_max_reg;
    logic [FILL_W-1:0] m_fill_reg;

    logic [CNT_W-1:0]    eff_w;
    logic [CNT_W-1:0]    pos_inc;
    logic [ADDR_W-1:0]   pos_next;
    logic [ADDR_W-1:0]   raddr;
    logic [SAMPLE_W-1:0] rdata;
    sample_t             rd_val;
    logic                full;
    sample_t             cur_max, cur_min;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = CNT_W'(1);
        end else if (32'(width_reg) > DEPTH) begin
            eff_w = CNT_W'(DEPTH);
        end else begin
            eff_w = CNT_W'(width_reg);
        end
    end

    assign rd_val = $signed(rdata);
    assign full   = count_reg >= eff_w;
    assign raddr  = cmd.accept ? pos_reg : scan_idx_reg;

    swmm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.eval),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.scan_needed = track_reg && full && count_reg != '0 &&
                                (rd_val == max_reg || rd_val == min_reg);
    assign status.scan_last   = CNT_W'(scan_idx_reg) == eff_w - CNT_W'(1);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_next = (pos_inc >= eff_w) ? '0 : ADDR_W'(pos_inc);

    always_comb begin
        cur_max  = (did_scan_reg && scan_max_reg)  ? best_reg : max_reg;
        cur_min  = (did_scan_reg && !scan_max_reg) ? best_reg : min_reg;
        max_next = max_reg;
        min_next = min_reg;
        if (track_reg) begin
            if (count_reg == '0) begin
                max_next = sample_reg;
                min_next = sample_reg;
            end else begin
                max_next = cur_max;
                min_next = cur_min;
                if (sample_reg > cur_max) begin
                    max_next = sample_reg;
                end else if (sample_reg < cur_min) begin
                    min_next = sample_reg;
                end
            end
        end
    end

    // config, position, count and tracked extremes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            track_reg <= 1'b1;
            pos_reg   <= '0;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WINDOW_WIDTH: begin
                    width_reg <= cfg_wdata;
                    pos_reg   <= '0;
                    count_reg <= '0;
                end
                REG_TRACKING: begin
                    track_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end else if (cmd.update) begin
            min_reg <= min_next;
            max_reg <= max_next;
            pos_reg <= pos_next;
            if (count_reg < eff_w) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // rescan sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            did_scan_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.eval) begin
                did_scan_reg <= status.scan_needed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.eval) begin
            scan_max_reg <= rd_val == max_reg;
            scan_idx_reg <= '0;
        end else if (cmd.scan_issue) begin
            scan_idx_reg <= scan_idx_reg + ADDR_W'(1);
        end
        rd_first_reg <= cmd.scan_issue && scan_idx_reg == '0;
        if (rd_vld_reg) begin
            if (rd_first_reg) begin
                best_reg <= rd_val;
            end else if (scan_max_reg ? (rd_val > best_reg) : (rd_val < best_reg)) begin
                best_reg <= rd_val;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_min_reg  <= min_reg;
            m_max_reg  <= max_reg;
            m_fill_reg <= FILL_W'(count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_min = m_min_reg;
    assign m_window_max = m_max_reg;
    assign m_fill_count = m_fill_reg;

endmodule

@@ hw/rtl/sliding_window_min_max_top.sv @@
// Sliding window min/max tracker, top level.
// Instantiates swmm_ctrl and swmm_dp; depends on swmm_pkg.
//
// Each input word carries one signed sample that is written into a circular
// window of window_width entries (0 acts as 1, above 128 acts as 128); every
// word returns the tracked minimum, maximum and fill count. An accepted word
// has its evicted entry read, is written and checked, then commits the new
// extremes, position and count and is loaded into the result register. When
// the window is full with tracking on and the overwritten sample was the
// current maximum or minimum, the window is rescanned one entry per cycle
// through the store's single read port before the commit. One word is in
// work at a time; the result register lets the next word be accepted
// while a result waits. Writing window_width restarts the window. Config
// writes must go in only while no word is in flight; no logic enforces it.
module sliding_window_min_max_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [swmm_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [swmm_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  swmm_pkg::sample_t              s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output swmm_pkg::sample_t              m_window_min,
    output swmm_pkg::sample_t              m_window_max,
    output logic [swmm_pkg::FILL_W-1:0]    m_fill_count
);
    import swmm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    swmm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swmm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_window_min (m_window_min),
        .m_window_max (m_window_max),
        .m_fill_count (m_fill_count),
        .cmd          (cmd),
        .status       (status)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while previous word in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register loaded over an untaken word");

    a_fill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_count != '0))
        else $error("result word with zero fill count");

    a_scan_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> !(cmd.update || cmd.out_load || s_ready))
        else $error("rescan overlaps other work");

endmodule
